@@ hdl/ahp_pkg.sv @@
// Altitude-hold PID: shared types, constants, microcode ROM and lookup tables.
// Used by altitude_hold_pid_unit; depends on nothing else.
package ahp_pkg;

  // Item payloads
  typedef struct packed {
    logic signed [1:0]  stick_dir;
    logic        [15:0] tick_seconds;
    logic signed [31:0] measured_altitude;
    logic signed [31:0] vertical_velocity;
  } ahp_in_t;

  typedef struct packed {
    logic signed [15:0] throttle;
    logic signed [31:0] target_now;
  } ahp_out_t;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_TARGET_STEP    = 3'd4,
    REG_TARGET_RATE    = 3'd5
  } ahp_reg_e;

  localparam int unsigned GAIN_W  = 20;
  localparam int unsigned LIMIT_W = 24;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned RATE_W  = 16;

  localparam logic [GAIN_W-1:0]  RST_GAIN_P = 20'd6554;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I = 20'd1311;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D = 20'd9830;
  localparam logic [LIMIT_W-1:0] RST_LIMIT  = 24'd655360;
  localparam logic [STEP_W-1:0]  RST_STEP   = 16'd2560;
  localparam logic [RATE_W-1:0]  RST_RATE   = 16'd500;

  // Arithmetic constants
  localparam logic [16:0]        FULL_FRAC = 17'h10000;       // 1.0 in Q1.16
  localparam logic [31:0]        RCP_25    = 32'd2748779070;  // ceil(2^36 / 25)
  localparam logic signed [15:0] THR_MAX   = 16'sd16384;      // 1.0 in Q1.14
  localparam logic signed [31:0] TGT_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] TGT_MIN   = 32'sh8000_0000;

  // Micro-operations
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_DT_RATE,
    MUL_STEP_FRAC,
    MUL_MAG_RCP,
    MUL_MAG_DT,
    MUL_MAG_GP,
    MUL_MAG_GI,
    MUL_MAG_GD
  } ahp_mul_e;

  typedef enum logic [3:0] {
    ALU_NONE,
    ALU_FRAC,
    ALU_TGT,
    ALU_ABS_DIFF,
    ALU_ABS_VEL,
    ALU_ABS_INT,
    ALU_CONV,
    ALU_INT_ADD,
    ALU_INT_CLAMP,
    ALU_DRIVE
  } ahp_alu_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } ahp_acc_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_WAIT_IN,
    C_NO_MOVE,
    C_WAIT_OUT
  } ahp_cond_e;

  // Program steps, in ROM order
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_RATE,
    ST_FRAC,
    ST_MUL_MOVE,
    ST_TGT,
    ST_ABS_DIFF,
    ST_ERR_RCP,
    ST_ERR_CONV,
    ST_MUL_DT,
    ST_INT_ADD,
    ST_INT_CLAMP,
    ST_ABS_INT,
    ST_MUL_GI,
    ST_ABS_VEL,
    ST_VEL_RCP,
    ST_VEL_CONV,
    ST_MUL_GD,
    ST_ACC_GD,
    ST_DRIVE
  } ahp_step_e;

  typedef struct packed {
    ahp_mul_e  mul;
    ahp_alu_e  alu;
    ahp_acc_e  acc;
    ahp_cond_e cond;
    ahp_step_e jump;
  } ahp_ctl_t;

  function automatic ahp_ctl_t ahp_uword(input ahp_mul_e m, input ahp_alu_e a,
                                         input ahp_acc_e c, input ahp_cond_e d,
                                         input ahp_step_e j);
    ahp_ctl_t w;
    w.mul  = m;
    w.alu  = a;
    w.acc  = c;
    w.cond = d;
    w.jump = j;
    return w;
  endfunction

  // Control ROM. The multiplier result lands in the product register at the end of
  // its step, so ALU and accumulator ops consume the previous step's product.
  function automatic ahp_ctl_t ahp_ucode(input ahp_step_e pc);
    ahp_ctl_t w;
    unique case (pc)
      ST_IDLE:      w = ahp_uword(MUL_NONE, ALU_NONE, ACC_NONE, C_WAIT_IN, ST_IDLE);
      ST_MUL_RATE:  w = ahp_uword(MUL_DT_RATE, ALU_NONE, ACC_NONE, C_NO_MOVE, ST_ABS_DIFF);
      ST_FRAC:      w = ahp_uword(MUL_NONE, ALU_FRAC, ACC_NONE, C_NEXT, ST_IDLE);
      ST_MUL_MOVE:  w = ahp_uword(MUL_STEP_FRAC, ALU_NONE, ACC_NONE, C_NEXT, ST_IDLE);
      ST_TGT:       w = ahp_uword(MUL_NONE, ALU_TGT, ACC_NONE, C_NEXT, ST_IDLE);
      ST_ABS_DIFF:  w = ahp_uword(MUL_NONE, ALU_ABS_DIFF, ACC_NONE, C_NEXT, ST_IDLE);
      ST_ERR_RCP:   w = ahp_uword(MUL_MAG_RCP, ALU_NONE, ACC_NONE, C_NEXT, ST_IDLE);
      ST_ERR_CONV:  w = ahp_uword(MUL_NONE, ALU_CONV, ACC_NONE, C_NEXT, ST_IDLE);
      ST_MUL_DT:    w = ahp_uword(MUL_MAG_DT, ALU_NONE, ACC_NONE, C_NEXT, ST_IDLE);
      ST_INT_ADD:   w = ahp_uword(MUL_MAG_GP, ALU_INT_ADD, ACC_NONE, C_NEXT, ST_IDLE);
      ST_INT_CLAMP: w = ahp_uword(MUL_NONE, ALU_INT_CLAMP, ACC_LOAD, C_NEXT, ST_IDLE);
      ST_ABS_INT:   w = ahp_uword(MUL_NONE, ALU_ABS_INT, ACC_NONE, C_NEXT, ST_IDLE);
      ST_MUL_GI:    w = ahp_uword(MUL_MAG_GI, ALU_NONE, ACC_NONE, C_NEXT, ST_IDLE);
      ST_ABS_VEL:   w = ahp_uword(MUL_NONE, ALU_ABS_VEL, ACC_ADD, C_NEXT, ST_IDLE);
      ST_VEL_RCP:   w = ahp_uword(MUL_MAG_RCP, ALU_NONE, ACC_NONE, C_NEXT, ST_IDLE);
      ST_VEL_CONV:  w = ahp_uword(MUL_NONE, ALU_CONV, ACC_NONE, C_NEXT, ST_IDLE);
      ST_MUL_GD:    w = ahp_uword(MUL_MAG_GD, ALU_NONE, ACC_NONE, C_NEXT, ST_IDLE);
      ST_ACC_GD:    w = ahp_uword(MUL_NONE, ALU_NONE, ACC_SUB, C_NEXT, ST_IDLE);
      ST_DRIVE:     w = ahp_uword(MUL_NONE, ALU_DRIVE, ACC_NONE, C_WAIT_OUT, ST_IDLE);
      default:      w = ahp_uword(MUL_NONE, ALU_NONE, ACC_NONE, C_JUMP, ST_IDLE);
    endcase
    return w;
  endfunction

  // floor(64*r/25) for a remainder r of a division by 25
  function automatic logic [5:0] ahp_cm_frac(input logic [4:0] r);
    logic [5:0] f;
    unique case (r)
      5'd0:    f = 6'd0;
      5'd1:    f = 6'd2;
      5'd2:    f = 6'd5;
      5'd3:    f = 6'd7;
      5'd4:    f = 6'd10;
      5'd5:    f = 6'd12;
      5'd6:    f = 6'd15;
      5'd7:    f = 6'd17;
      5'd8:    f = 6'd20;
      5'd9:    f = 6'd23;
      5'd10:   f = 6'd25;
      5'd11:   f = 6'd28;
      5'd12:   f = 6'd30;
      5'd13:   f = 6'd33;
      5'd14:   f = 6'd35;
      5'd15:   f = 6'd38;
      5'd16:   f = 6'd40;
      5'd17:   f = 6'd43;
      5'd18:   f = 6'd46;
      5'd19:   f = 6'd48;
      5'd20:   f = 6'd51;
      5'd21:   f = 6'd53;
      5'd22:   f = 6'd56;
      5'd23:   f = 6'd58;
      5'd24:   f = 6'd61;
      default: f = 6'd0;
    endcase
    return f;
  endfunction

endpackage

@@ hdl/altitude_hold_pid_unit.sv @@
// Altitude-hold PID controller: microcoded sequencer over one shared multiplier.
// Depends on ahp_pkg (payload types, control ROM, constants).
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one control tick
//   per item; output channel (out_valid_o / out_stall_i / out_item_o) returns
//   one result (throttle, updated target) per item. Configuration writes go
//   through cfg_valid_i / cfg_ready_o with a register index and data; ready is
//   always high. Write configuration only while the block is idle.
// Sequencing:
//   The sequencer steps through a 19-word control ROM, one word per cycle except
//   while it waits in idle or on its last step, all products going through a
//   single 34x32 multiplier. The target move is skipped when stick_dir is zero.
//   A new item is taken only once the sequencer is back in idle.
// Stalls:
//   The result sits in an output register; the sequencer only parks on its
//   last step if that register is still full when the next result is ready.
// Reset:
//   Clears the target altitude and integrator, loads the default gains and
//   limits, and returns the sequencer to idle with no result pending.
module altitude_hold_pid_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  ahp_pkg::ahp_in_t                 in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output ahp_pkg::ahp_out_t                out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ahp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ahp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ahp_pkg::*;

  // Sequencer
  ahp_step_e pc_q, pc_d;
  ahp_ctl_t  ctl;

  // Configuration registers
  logic [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [STEP_W-1:0]  step_q;
  logic [RATE_W-1:0]  rate_q;

  // Captured item
  logic signed [1:0]  dir_q;
  logic [15:0]        dt_q;
  logic signed [31:0] alt_q;
  logic signed [31:0] vel_q;

  // Datapath registers
  logic [63:0]        prod_q;
  logic [16:0]        frac_q;
  logic signed [31:0] tgt_q;
  logic [33:0]        mag_q;
  logic               neg_q;
  logic [35:0]        sum_q;
  logic signed [24:0] integ_q;
  logic [55:0]        acc_q;
  logic               out_valid_q;
  ahp_out_t           out_item_q;

  logic in_accept, out_free, out_load, cfg_we;

  // Multiplier operands and result
  logic [33:0] mul_a;
  logic [31:0] mul_b;
  logic [65:0] mul_p;

  // ALU results
  logic [16:0]        frac_new;
  logic [15:0]        move;
  logic [32:0]        tgt_ext, tgt_sum;
  logic signed [31:0] tgt_new;
  logic [32:0]        diff_ta, diff_at, vel_neg33;
  logic [31:0]        diff_mag, vel_mag;
  logic [24:0]        int_neg25, int_mag;
  logic [27:0]        quo;
  logic [9:0]         q25;
  logic [4:0]         rem;
  logic [33:0]        conv_mag;
  logic [33:0]        ix;
  logic               inz;
  logic [35:0]        addend, sum_new;
  logic [24:0]        lim25, neg_lim25;
  logic [35:0]        lim36, neg_lim36;
  logic [24:0]        integ_new;
  logic [55:0]        acc_p, acc_base, acc_new;
  logic               acc_pn;
  logic signed [37:0] drv;
  logic signed [15:0] thr;

  assign ctl        = ahp_ucode(pc_q);
  assign in_stall_o = (pc_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (ctl.alu == ALU_DRIVE) && out_free;
  assign cfg_ready_o = 1'b1;
  assign cfg_we     = cfg_valid_i && cfg_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Next step
  always_comb begin
    pc_d = pc_q;
    unique case (ctl.cond)
      C_NEXT:     pc_d = ahp_step_e'(pc_q + 1'b1);
      C_JUMP:     pc_d = ctl.jump;
      C_WAIT_IN:  if (in_accept) pc_d = ahp_step_e'(pc_q + 1'b1);
      C_NO_MOVE:  pc_d = (dir_q == 2'sb00) ? ctl.jump : ahp_step_e'(pc_q + 1'b1);
      C_WAIT_OUT: if (out_free) pc_d = ctl.jump;
      default:    pc_d = ST_IDLE;
    endcase
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.mul)
      MUL_DT_RATE: begin
        mul_a = 34'(dt_q);
        mul_b = 32'(rate_q);
      end
      MUL_STEP_FRAC: begin
        mul_a = 34'(step_q);
        mul_b = 32'(frac_q[15:0]);
      end
      MUL_MAG_RCP: begin
        mul_a = mag_q;
        mul_b = RCP_25;
      end
      MUL_MAG_DT: begin
        mul_a = mag_q;
        mul_b = 32'(dt_q);
      end
      MUL_MAG_GP: begin
        mul_a = mag_q;
        mul_b = 32'(gain_p_q);
      end
      MUL_MAG_GI: begin
        mul_a = mag_q;
        mul_b = 32'(gain_i_q);
      end
      MUL_MAG_GD: begin
        mul_a = mag_q;
        mul_b = 32'(gain_d_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 66'(mul_a) * 66'(mul_b);

  // Step fraction, clamped to one; zero rate means a full step
  assign frac_new = ((rate_q == '0) || (prod_q[31:0] > 32'(FULL_FRAC))) ? FULL_FRAC
                                                                          : prod_q[16:0];

  // Target move with saturation to the 32-bit range
  assign move    = frac_q[16] ? step_q : prod_q[31:16];
  assign tgt_ext = {tgt_q[31], tgt_q};
  assign tgt_sum = dir_q[1] ? (tgt_ext - {17'b0, move}) : (tgt_ext + {17'b0, move});
  assign tgt_new = (tgt_sum[32] != tgt_sum[31]) ? (tgt_sum[32] ? TGT_MIN : TGT_MAX)
                                                : tgt_sum[31:0];

  // Magnitudes: error, velocity, integral
  assign diff_ta   = {tgt_q[31], tgt_q} - {alt_q[31], alt_q};
  assign diff_at   = {alt_q[31], alt_q} - {tgt_q[31], tgt_q};
  assign diff_mag  = diff_ta[32] ? diff_at[31:0] : diff_ta[31:0];
  assign vel_neg33 = 33'd0 - {vel_q[31], vel_q};
  assign vel_mag   = vel_q[31] ? vel_neg33[31:0] : vel_q[31:0];
  assign int_neg25 = 25'd0 - integ_q;
  assign int_mag   = integ_q[24] ? int_neg25 : integ_q;

  // cm to m: 64*a/25 = 64*(a/25) + floor(64*(a%25)/25)
  assign quo      = prod_q[63:36];
  assign q25      = 10'(quo[4:0]) * 10'd25;
  assign rem      = mag_q[4:0] - q25[4:0];
  assign conv_mag = {quo, ahp_cm_frac(rem)};

  // Integrator update: floor of the signed product, one adder with carry-in
  assign ix      = prod_q[49:16];
  assign inz     = |prod_q[15:0];
  assign addend  = neg_q ? ~{2'b00, ix} : {2'b00, ix};
  assign sum_new = {{11{integ_q[24]}}, integ_q} + addend + 36'(neg_q && !inz);

  // Integrator clamp
  assign lim25     = {1'b0, limit_q};
  assign neg_lim25 = 25'd0 - lim25;
  assign lim36     = {12'b0, limit_q};
  assign neg_lim36 = 36'd0 - lim36;
  always_comb begin
    priority if ($signed(sum_q) > $signed(lim36)) begin
      integ_new = lim25;
    end else if ($signed(sum_q) < $signed(neg_lim36)) begin
      integ_new = neg_lim25;
    end else begin
      integ_new = sum_q[24:0];
    end
  end

  // Drive accumulator: signed add of the last product
  assign acc_p    = {1'b0, prod_q[54:0]};
  assign acc_pn   = neg_q ^ (ctl.acc == ACC_SUB);
  assign acc_base = (ctl.acc == ACC_LOAD) ? '0 : acc_q;
  assign acc_new  = acc_base + (acc_pn ? ~acc_p : acc_p) + 56'(acc_pn);

  // Output scaling: floor by 2^18 then clamp to one full scale
  assign drv = acc_q[55:18];
  always_comb begin
    priority if (drv > THR_MAX) begin
      thr = THR_MAX;
    end else if (drv < -THR_MAX) begin
      thr = -THR_MAX;
    end else begin
      thr = drv[15:0];
    end
  end

  // Control state, configuration and persistent loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= ST_IDLE;
      gain_p_q    <= RST_GAIN_P;
      gain_i_q    <= RST_GAIN_I;
      gain_d_q    <= RST_GAIN_D;
      limit_q     <= RST_LIMIT;
      step_q      <= RST_STEP;
      rate_q      <= RST_RATE;
      tgt_q       <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (cfg_we) begin
        unique case (ahp_reg_e'(cfg_index_i))
          REG_GAIN_P:         gain_p_q <= cfg_data_i[GAIN_W-1:0];
          REG_GAIN_I:         gain_i_q <= cfg_data_i[GAIN_W-1:0];
          REG_GAIN_D:         gain_d_q <= cfg_data_i[GAIN_W-1:0];
          REG_INTEGRAL_LIMIT: limit_q  <= cfg_data_i[LIMIT_W-1:0];
          REG_TARGET_STEP:    step_q   <= cfg_data_i[STEP_W-1:0];
          REG_TARGET_RATE:    rate_q   <= cfg_data_i[RATE_W-1:0];
          default: ;
        endcase
      end
      if (ctl.alu == ALU_TGT) begin
        tgt_q <= tgt_new;
      end
      if (ctl.alu == ALU_INT_CLAMP) begin
        integ_q <= integ_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item capture and datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      dir_q <= in_item_i.stick_dir;
      dt_q  <= in_item_i.tick_seconds;
      alt_q <= in_item_i.measured_altitude;
      vel_q <= in_item_i.vertical_velocity;
    end
    if (ctl.mul != MUL_NONE) begin
      prod_q <= mul_p[63:0];
    end
    if (ctl.acc != ACC_NONE) begin
      acc_q <= acc_new;
    end
    unique case (ctl.alu)
      ALU_FRAC:     frac_q <= frac_new;
      ALU_ABS_DIFF: begin
        mag_q <= 34'(diff_mag);
        neg_q <= diff_ta[32];
      end
      ALU_ABS_VEL: begin
        mag_q <= 34'(vel_mag);
        neg_q <= vel_q[31];
      end
      ALU_ABS_INT: begin
        mag_q <= 34'(int_mag);
        neg_q <= integ_q[24];
      end
      ALU_CONV:     mag_q <= conv_mag;
      ALU_INT_ADD:  sum_q <= sum_new;
      ALU_DRIVE: begin
        if (out_free) begin
          out_item_q.throttle   <= thr;
          out_item_q.target_now <= tgt_q;
        end
      end
      default: ;
    endcase
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("sequencer did not start after an accepted item");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == ST_IDLE) && !in_accept |=> (pc_q == ST_IDLE))
    else $error("sequencer left idle without an item");

  a_result_from_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(pc_q) == ST_DRIVE))
    else $error("result loaded outside the drive step");

  a_throttle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_item_q.throttle <= THR_MAX) && (out_item_q.throttle >= -THR_MAX)))
    else $error("throttle outside full scale");

  a_integral_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == ST_ABS_INT) |->
      (($signed({integ_q[24], integ_q}) <= $signed({2'b00, limit_q})) &&
       ($signed({integ_q[24], integ_q}) >= -$signed({2'b00, limit_q}))))
    else $error("integrator outside its limit after clamp");

  a_frac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == ST_TGT) |-> (frac_q <= FULL_FRAC))
    else $error("step fraction above one");

endmodule
